// ===== sv/spq_pkg.sv =====
package spq_pkg;

  localparam int KIND_W    = 2;
  localparam int RANK_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int WORD_W    = 32;
  localparam int OCC_W     = 5;

  // operation codes; the unused code behaves as a peek
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic load;  // capture the operation on a start transfer
    logic exec;  // apply it to the entry row and register the result
  } spq_cmd_t;

endpackage

// ===== sv/spq_ctrl.sv =====
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output logic     done_o,
  output spq_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign done_d     = (state_q == ST_EXEC);
  assign cmd_o.load = (state_q == ST_IDLE) && start;
  assign cmd_o.exec = (state_q == ST_EXEC);
  assign busy       = (state_q == ST_EXEC);
  assign done_o     = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

endmodule

// ===== sv/spq_datapath.sv =====
module spq_datapath
  import spq_pkg::*;
#(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_cmd_t            cmd_i,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [WORD_W-1:0]   payload_i,
  input  logic [RANK_W-1:0]   rank_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [WORD_W-1:0]   head_payload_o,
  output logic [RANK_W-1:0]   head_rank_o,
  output logic [OCC_W-1:0]    occupancy_o
);

  localparam int CW = $clog2(DEPTH + 1);

  // captured operation
  logic [KIND_W-1:0]       kind_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [RANK_W-1:0]       rank_q;

  // sorted entry row, head in slot 0
  logic [PAYLOAD_BITS-1:0] pay_row_q  [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_row_d  [DEPTH];
  logic [RANK_W-1:0]       rank_row_q [DEPTH];
  logic [RANK_W-1:0]       rank_row_d [DEPTH];
  logic [CW-1:0]           count_q, count_d;

  logic [DEPTH-1:0] used;
  logic [DEPTH-1:0] larger;
  logic [DEPTH-1:0] tail;
  logic             full, empty;

  logic [STATUS_W-1:0]     status_d, status_q;
  logic [PAYLOAD_BITS-1:0] hpay_d;
  logic [RANK_W-1:0]       hrank_d;
  logic [WORD_W-1:0]       hpay_q;
  logic [RANK_W-1:0]       hrank_q;
  logic [OCC_W-1:0]        occ_q;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  // per-slot compare against the captured rank
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      used[j]   = (CW'(j) < count_q);
      larger[j] = used[j] && (rank_row_q[j] > rank_q);
      tail[j]   = (CW'(j) == count_q);
    end
  end

  always_comb begin
    pay_row_d  = pay_row_q;
    rank_row_d = rank_row_q;
    count_d    = count_q;
    status_d   = STATUS_DONE;
    hpay_d     = pay_row_q[0];
    hrank_d    = rank_row_q[0];
    case (kind_q)
      KIND_INSERT: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          count_d = count_q + CW'(1);
          // slot 0 has no predecessor
          if (larger[0] || tail[0]) begin
            pay_row_d[0]  = pay_q;
            rank_row_d[0] = rank_q;
          end
          for (int j = 1; j < DEPTH; j++) begin
            if (larger[j-1]) begin
              pay_row_d[j]  = pay_row_q[j-1];
              rank_row_d[j] = rank_row_q[j-1];
            end else if (larger[j] || tail[j]) begin
              pay_row_d[j]  = pay_q;
              rank_row_d[j] = rank_q;
            end
          end
          hpay_d  = pay_row_d[0];
          hrank_d = rank_row_d[0];
        end
      end
      KIND_REMOVE: begin
        if (empty) begin
          status_d = STATUS_EMPTY;
          hpay_d   = '0;
          hrank_d  = '0;
        end else begin
          count_d = count_q - CW'(1);
          for (int j = 0; j < DEPTH - 1; j++) begin
            pay_row_d[j]  = pay_row_q[j+1];
            rank_row_d[j] = rank_row_q[j+1];
          end
        end
      end
      default: begin
        if (empty) begin
          status_d = STATUS_EMPTY;
          hpay_d   = '0;
          hrank_d  = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      pay_q  <= PAYLOAD_BITS'(payload_i);
      rank_q <= rank_i;
    end
    if (cmd_i.exec) begin
      pay_row_q  <= pay_row_d;
      rank_row_q <= rank_row_d;
      status_q   <= status_d;
      hpay_q     <= WORD_W'(hpay_d);
      hrank_q    <= hrank_d;
      occ_q      <= OCC_W'(count_d);
    end
  end

  assign status_o       = status_q;
  assign head_payload_o = hpay_q;
  assign head_rank_o    = hrank_q;
  assign occupancy_o    = occ_q;

endmodule

// ===== sv/sorted_priority_queue_unit.sv =====
// Bounded priority queue of DEPTH entries kept sorted by ascending rank; the
// lowest rank is served first and equal ranks leave in arrival order. An
// operation (insert, remove head, peek head) is taken on a clock edge with
// start high and busy low. Each operation is captured, then all slots
// compare against the new rank and shift in parallel. Its single result
// appears on the result ports for exactly one cycle with done_o high, as
// busy falls; the receiver cannot stall, so it must take the result in that
// cycle. A refused insert shows status full and the current head, a refused
// remove or peek shows status empty with zero head fields. For a remove the
// head fields give the entry that left. A new operation may start in the
// same cycle the result shows.
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [WORD_W-1:0]   payload_i,
  input  logic [RANK_W-1:0]   rank_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [WORD_W-1:0]   head_payload_o,
  output logic [RANK_W-1:0]   head_rank_o,
  output logic [OCC_W-1:0]    occupancy_o
);

  spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  spq_datapath #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .kind_i         (kind_i),
    .payload_i      (payload_i),
    .rank_i         (rank_i),
    .status_o       (status_o),
    .head_payload_o (head_payload_o),
    .head_rank_o    (head_rank_o),
    .occupancy_o    (occupancy_o)
  );

endmodule
